// File: src/aaec_pkg.sv
// Shared types and constants for the accessory attach event classifier.
package aaec_pkg;

    localparam logic [7:0] T1_USB      = 8'h84;
    localparam logic [7:0] T1_UART     = 8'h08;
    localparam logic [7:0] T1_CHG      = 8'h70;
    localparam logic [7:0] T2_USB      = 8'h03;
    localparam logic [7:0] T2_UART     = 8'h0C;
    localparam logic [7:0] T2_JIG      = 8'h0F;
    localparam logic [7:0] RED_T1      = 8'h74;
    localparam logic [7:0] RED_T2      = 8'h8F;
    localparam logic [7:0] RED_CTRL    = 8'h15;
    localparam logic [7:0] PATH_SERIAL = 8'h6C;
    localparam logic [7:0] VBUS_BIT    = 8'h02;
    localparam logic [7:0] CTRL_SEL    = 8'h04;
    localparam logic [7:0] CTRL_INTMASK_CLR = 8'hFE;

    localparam logic [7:0] INT_ATTACH  = 8'h01;
    localparam logic [7:0] INT_DETACH  = 8'h02;
    localparam logic [7:0] INT_OVP_ON  = 8'h20;
    localparam logic [7:0] INT_OVP_OFF = 8'h80;

    localparam logic [4:0] N_USB  = 5'h01;
    localparam logic [4:0] N_UART = 5'h02;
    localparam logic [4:0] N_CHG  = 5'h04;
    localparam logic [4:0] N_JIG  = 5'h08;
    localparam logic [4:0] N_OVP  = 5'h10;

    localparam logic [1:0] VARIANT_REDUCED = 2'd2;
    localparam logic [4:0] HANDLER_RESET   = 5'h1F;

    typedef enum logic [1:0] {
        REG_CHIP_VARIANT    = 2'd0,
        REG_MANUAL_PATH     = 2'd1,
        REG_HANDLER_PRESENT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] int_status;
        logic [7:0] type_one;
        logic [7:0] type_two;
        logic [7:0] ctrl_read;
        logic [7:0] vbus_byte;
    } item_t;

    typedef struct packed {
        logic [4:0] attach_mask;
        logic [4:0] detach_mask;
        logic       path_write;
        logic [7:0] path_value;
        logic       ctrl_reset;
        logic [7:0] ctrl_final;
    } result_t;

    typedef struct packed {
        logic [7:0] prev_type_one;
        logic [7:0] prev_type_two;
        logic       ovp_active;
        logic       jig_vbus_active;
    } state_t;

    typedef struct packed {
        logic [1:0] chip_variant;
        logic [7:0] manual_path;
        logic [4:0] handler_present;
    } cfg_t;

endpackage

// File: src/aaec_if.sv
// Stream and configuration interfaces of the classifier.
interface aaec_evt_if;
    logic       valid;
    logic       ready;
    logic [7:0] int_status;
    logic [7:0] type_one;
    logic [7:0] type_two;
    logic [7:0] ctrl_read;
    logic [7:0] vbus_byte;

    modport source (output valid, int_status, type_one, type_two, ctrl_read, vbus_byte,
                    input ready);
    modport sink   (input valid, int_status, type_one, type_two, ctrl_read, vbus_byte,
                    output ready);
endinterface

interface aaec_res_if;
    logic       valid;
    logic       ready;
    logic [4:0] attach_mask;
    logic [4:0] detach_mask;
    logic       path_write;
    logic [7:0] path_value;
    logic       ctrl_reset;
    logic [7:0] ctrl_final;

    modport source (output valid, attach_mask, detach_mask, path_write, path_value,
                    ctrl_reset, ctrl_final, input ready);
    modport sink   (input valid, attach_mask, detach_mask, path_write, path_value,
                    ctrl_reset, ctrl_final, output ready);
endinterface

interface aaec_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/aaec_cfg_regs.sv
// Configuration register file of the classifier.
module aaec_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    aaec_cfg_if.sink           cfg,
    output aaec_pkg::cfg_t     cfg_q
);

    aaec_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chip_variant    <= '0;
            cfg_reg.manual_path     <= '0;
            cfg_reg.handler_present <= aaec_pkg::HANDLER_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (aaec_pkg::cfg_reg_t'(cfg.index))
                aaec_pkg::REG_CHIP_VARIANT:    cfg_reg.chip_variant    <= cfg.data[1:0];
                aaec_pkg::REG_MANUAL_PATH:     cfg_reg.manual_path     <= cfg.data;
                aaec_pkg::REG_HANDLER_PRESENT: cfg_reg.handler_present <= cfg.data[4:0];
                default: ;
            endcase
        end
    end

endmodule

// File: src/aaec_classify.sv
// Combinational event classification and state update.
module aaec_classify
(
    input  aaec_pkg::item_t    item,
    input  aaec_pkg::state_t   state,
    input  aaec_pkg::cfg_t     cfg,
    output aaec_pkg::result_t  res,
    output aaec_pkg::state_t   state_next
);

    logic [7:0] t1;
    logic [7:0] t2;
    logic [7:0] ctrl;
    logic [7:0] intr;
    logic [4:0] hp;
    logic       vbus;
    logic       empty;
    logic       prev_empty;
    logic [4:0] empty_det;

    always_comb
    begin
        intr = item.int_status;
        hp   = cfg.handler_present;
        vbus = |(item.vbus_byte & aaec_pkg::VBUS_BIT);
        t1   = item.type_one;
        t2   = item.type_two;
        ctrl = item.ctrl_read;
        if (cfg.chip_variant == aaec_pkg::VARIANT_REDUCED)
        begin
            t1   = t1 & aaec_pkg::RED_T1;
            t2   = t2 & aaec_pkg::RED_T2;
            ctrl = ctrl & aaec_pkg::RED_CTRL;
        end
        empty      = (t1 == '0) && (t2 == '0);
        prev_empty = (state.prev_type_one == '0) && (state.prev_type_two == '0);

        empty_det = '0;
        if (|(state.prev_type_one & aaec_pkg::T1_USB) || |(state.prev_type_two & aaec_pkg::T2_USB))
            empty_det = empty_det | (aaec_pkg::N_USB & hp);
        if (|(state.prev_type_one & aaec_pkg::T1_CHG))
            empty_det = empty_det | (aaec_pkg::N_CHG & hp);

        res        = '0;
        state_next = state;
        res.ctrl_final = ctrl & aaec_pkg::CTRL_INTMASK_CLR;

        if (|(intr & aaec_pkg::INT_ATTACH))
        begin
            if (|(t1 & aaec_pkg::T1_USB) || |(t2 & aaec_pkg::T2_USB))
            begin
                res.attach_mask = res.attach_mask | (aaec_pkg::N_USB & hp);
                if (cfg.manual_path != '0)
                begin
                    res.path_write = 1'b1;
                    res.path_value = cfg.manual_path;
                end
            end
            if (|(t1 & aaec_pkg::T1_UART) || |(t2 & aaec_pkg::T2_UART))
            begin
                res.attach_mask = res.attach_mask | (aaec_pkg::N_UART & hp);
                if (!(|(ctrl & aaec_pkg::CTRL_SEL)))
                begin
                    res.path_write = 1'b1;
                    res.path_value = aaec_pkg::PATH_SERIAL;
                end
            end
            if (|(t1 & aaec_pkg::T1_CHG))
                res.attach_mask = res.attach_mask | (aaec_pkg::N_CHG & hp);
            if (|(t2 & aaec_pkg::T2_JIG) && |(hp & aaec_pkg::N_JIG))
            begin
                if (vbus)
                begin
                    res.attach_mask = res.attach_mask | (aaec_pkg::N_CHG & hp);
                    state_next.jig_vbus_active = 1'b1;
                end
                else
                begin
                    res.attach_mask = res.attach_mask | aaec_pkg::N_JIG;
                end
            end
            if (empty)
            begin
                res.detach_mask = res.detach_mask | empty_det;
                res.ctrl_reset  = 1'b1;
            end
            else if (|(intr & aaec_pkg::INT_OVP_ON))
            begin
                res.attach_mask = res.attach_mask | (aaec_pkg::N_OVP & hp);
                state_next.ovp_active = 1'b1;
            end
        end
        else if (|(intr & aaec_pkg::INT_DETACH))
        begin
            if (|(state.prev_type_one & aaec_pkg::T1_USB)
                || |(state.prev_type_two & aaec_pkg::T2_USB))
                res.detach_mask = res.detach_mask | (aaec_pkg::N_USB & hp);
            if (|(state.prev_type_one & aaec_pkg::T1_UART)
                || |(state.prev_type_two & aaec_pkg::T2_UART))
                res.detach_mask = res.detach_mask | (aaec_pkg::N_UART & hp);
            if (|(state.prev_type_one & aaec_pkg::T1_CHG))
                res.detach_mask = res.detach_mask | (aaec_pkg::N_CHG & hp);
            if (|(state.prev_type_two & aaec_pkg::T2_JIG) && |(hp & aaec_pkg::N_JIG))
            begin
                if (state.jig_vbus_active)
                begin
                    res.detach_mask = res.detach_mask | (aaec_pkg::N_CHG & hp);
                    state_next.jig_vbus_active = 1'b0;
                end
                else
                begin
                    res.detach_mask = res.detach_mask | aaec_pkg::N_JIG;
                end
            end
            if (prev_empty)
            begin
                res.detach_mask = res.detach_mask | (aaec_pkg::N_CHG & hp);
                res.ctrl_reset  = 1'b1;
            end
            if (|(intr & aaec_pkg::INT_OVP_OFF) && state.ovp_active)
            begin
                res.detach_mask = res.detach_mask | (aaec_pkg::N_OVP & hp);
                state_next.ovp_active = 1'b0;
            end
        end
        else if (intr == '0)
        begin
            if (empty)
            begin
                res.detach_mask = res.detach_mask | empty_det;
                res.ctrl_reset  = 1'b1;
            end
        end
        else if (|(intr & aaec_pkg::INT_OVP_ON))
        begin
            res.attach_mask = res.attach_mask | (aaec_pkg::N_OVP & hp);
            state_next.ovp_active = 1'b1;
        end
        else if (|(intr & aaec_pkg::INT_OVP_OFF) && state.ovp_active)
        begin
            res.detach_mask = res.detach_mask | (aaec_pkg::N_OVP & hp);
            state_next.ovp_active = 1'b0;
        end

        state_next.prev_type_one = t1;
        state_next.prev_type_two = t2;
    end

endmodule

// File: src/accessory_attach_event_classifier.sv
// Top level of the accessory attach event classifier.
// Takes one switch interrupt event per cycle on evt while res.ready does not stall it, and
// returns one result word per event on res, in order. An event is held in the input register
// and classified on its way into the result register; the sustained rate is one event per
// clock without back-pressure. The stored previous types and the over-voltage and JIG-VBUS
// flags are updated in the same cycle as the result register is loaded, which sets the rate.
// The user must write registers through cfg (index 0 chip variant, 1 manual path, 2 handlers
// present) only while no event is in flight; the block itself does not enforce it.
module accessory_attach_event_classifier
(
    input  logic        clk,
    input  logic        rst_n,
    aaec_evt_if.sink    evt,
    aaec_res_if.source  res,
    aaec_cfg_if.sink    cfg
);

    aaec_pkg::cfg_t    cfg_q;
    aaec_pkg::item_t   evt_reg;
    logic              evt_valid_reg;
    aaec_pkg::result_t res_reg;
    aaec_pkg::result_t res_next;
    logic              res_valid_reg;
    aaec_pkg::state_t  state_reg;
    aaec_pkg::state_t  state_next;
    logic              res_free;
    logic              advance;

    aaec_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    aaec_classify u_classify
    (
        .item       (evt_reg),
        .state      (state_reg),
        .cfg        (cfg_q),
        .res        (res_next),
        .state_next (state_next)
    );

    assign res_free  = !res_valid_reg || res.ready;
    assign advance   = evt_valid_reg && res_free;
    assign evt.ready = !evt_valid_reg || res_free;

    assign res.valid       = res_valid_reg;
    assign res.attach_mask = res_reg.attach_mask;
    assign res.detach_mask = res_reg.detach_mask;
    assign res.path_write  = res_reg.path_write;
    assign res.path_value  = res_reg.path_value;
    assign res.ctrl_reset  = res_reg.ctrl_reset;
    assign res.ctrl_final  = res_reg.ctrl_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (evt.ready)
                evt_valid_reg <= evt.valid;
            if (res_free)
                res_valid_reg <= evt_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            evt_reg.int_status <= evt.int_status;
            evt_reg.type_one   <= evt.type_one;
            evt_reg.type_two   <= evt.type_two;
            evt_reg.ctrl_read  <= evt.ctrl_read;
            evt_reg.vbus_byte  <= evt.vbus_byte;
        end
        if (advance)
            res_reg <= res_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((res_reg.attach_mask & res_reg.detach_mask) == '0))
        else $error("attach and detach masks overlap");

    a_path_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.path_write) |-> (res_reg.path_value == '0))
        else $error("path value without path write");

    a_ctrl_bit0: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !res_reg.ctrl_final[0])
        else $error("control write keeps interrupt mask bit");

    a_ovp_set: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.ovp_active) |-> $past(advance && evt_reg.int_status[5]))
        else $error("over-voltage flag set without an over-voltage event");

    a_jig_set: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.jig_vbus_active)
            |-> $past(advance && evt_reg.int_status[0] && cfg_q.handler_present[3]))
        else $error("JIG-VBUS flag set without a JIG attach");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(state_reg))
        else $error("state changed without a word moving on");

endmodule
